// ----- hdl/pla_pkg.sv -----
// Shared types and constants for the pool allocator with used list.
// Used by pla_link_ram, pool_allocator_with_used_list_top and the testbench; no dependencies.
package pla_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 1024;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STRIDE_W = 16;
  localparam int unsigned REG_W   = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0]  POOL_LIMIT_RST   = 11'd1024;
  localparam logic [ADDR_W-1:0]   POOL_BASE_RST    = 32'd0;
  localparam logic [STRIDE_W-1:0] ENTRY_STRIDE_RST = 16'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC       = 3'd0,
    CMD_RELEASE     = 3'd1,
    CMD_RELEASE_ALL = 3'd2,
    CMD_FIRST       = 3'd3,
    CMD_NEXT        = 3'd4
  } pla_cmd_e;

  typedef enum logic [REG_W-1:0] {
    REG_POOL_LIMIT   = 2'd0,
    REG_POOL_BASE    = 2'd1,
    REG_ENTRY_STRIDE = 2'd2
  } pla_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WR2,
    ST_WR3,
    ST_RESP
  } pla_state_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] entry_index;
  } pla_req_t;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  granted_index;
    logic [ADDR_W-1:0] entry_address;
  } pla_rsp_t;

endpackage

// ----- hdl/pla_link_ram.sv -----
// Single-port-write, single-port-read link memory with registered read data.
// Depends on pla_pkg only for the default depth; no submodules.
module pla_link_ram
  import pla_pkg::*;
#(
  parameter int unsigned DEPTH = POOL_DEPTH_DEF,
  parameter int unsigned WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pool_allocator_with_used_list_top.sv -----
// Top level of the pool allocator: command sequencer, list registers, config registers.
// Depends on pla_pkg and two pla_link_ram instances (next and prev links).
//
// A command is taken when start is high and busy is low; its answer appears on
// result_o for exactly one cycle with done_o high, and the receiver cannot stall
// it. The links live in two memories with one write port each, read once right
// at the command's acceptance, so a command's length is set by how many link words it
// rewrites: a release of a valid index passes through EXEC, WR2, WR3 and RESP, a
// successful allocate through EXEC, WR2 and RESP, and every other command (including
// a failed allocate) through EXEC and RESP. Configuration writes are always ready and
// take effect at once; they are meant for when the block is idle.
module pool_allocator_with_used_list_top
  import pla_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pla_req_t              req_i,
  output logic                  done_o,
  output pla_rsp_t              result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [REG_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned IW = $clog2(POOL_DEPTH);
  localparam logic [LW-1:0] LINK_NONE = LW'(POOL_DEPTH);

  pla_state_e state_q, state_d;

  logic [LIMIT_W-1:0]  pool_limit_q;
  logic [ADDR_W-1:0]   pool_base_q;
  logic [STRIDE_W-1:0] entry_stride_q;

  logic [LW-1:0] bump_q, bump_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] free_tail_q, free_tail_d;
  logic [LW-1:0] used_head_q, used_head_d;
  logic [LW-1:0] used_tail_q, used_tail_d;

  pla_req_t      req_q;
  logic [LW-1:0] ent_q, ent_d;
  logic [LW-1:0] aux_q, aux_d;
  logic [LW-1:0] got_q, got_d;
  logic          ok_q, ok_d;

  logic     done_q, done_d;
  pla_rsp_t rsp_q, rsp_d;

  logic          accept;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [LW-1:0] rd_next, rd_prev;

  logic          nx_we, pv_we;
  logic [IW-1:0] nx_waddr, pv_waddr;
  logic [LW-1:0] nx_wdata, pv_wdata;

  logic          idx_ok;
  logic [LW-1:0] idx_l;
  logic [LW-1:0] limit;
  logic          alloc_ok;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = rsp_q;

  assign rd_en   = accept;
  assign rd_addr = (req_i.cmd == CMD_ALLOC) ? free_head_q[IW-1:0] : IW'(req_i.entry_index);

  pla_link_ram #(.DEPTH(POOL_DEPTH), .WIDTH(LW)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_next)
  );

  pla_link_ram #(.DEPTH(POOL_DEPTH), .WIDTH(LW)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_prev)
  );

  assign idx_ok = (32'(req_q.entry_index) < 32'(POOL_DEPTH));
  assign idx_l  = LW'(req_q.entry_index);
  assign limit  = (32'(pool_limit_q) > 32'(POOL_DEPTH)) ? LINK_NONE : LW'(pool_limit_q);
  assign alloc_ok = (free_head_q < LINK_NONE) || (bump_q < limit);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
        if (req_q.cmd == CMD_ALLOC && alloc_ok) state_d = ST_WR2;
        if (req_q.cmd == CMD_RELEASE && idx_ok) state_d = ST_WR2;
      end
      ST_WR2: begin
        state_d = (req_q.cmd == CMD_RELEASE) ? ST_WR3 : ST_RESP;
      end
      ST_WR3:  state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    bump_d      = bump_q;
    free_head_d = free_head_q;
    free_tail_d = free_tail_q;
    used_head_d = used_head_q;
    used_tail_d = used_tail_q;
    ent_d       = ent_q;
    aux_d       = aux_q;
    got_d       = got_q;
    ok_d        = ok_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    nx_we       = 1'b0;
    nx_waddr    = '0;
    nx_wdata    = '0;
    pv_we       = 1'b0;
    pv_waddr    = '0;
    pv_wdata    = '0;

    case (state_q)
      ST_EXEC: begin
        ok_d  = 1'b0;
        got_d = '0;
        case (req_q.cmd)
          CMD_ALLOC: begin
            if (alloc_ok) begin
              if (free_head_q < LINK_NONE) begin
                ent_d = free_head_q;
                if (rd_next < LINK_NONE) begin
                  free_head_d = rd_next;
                  pv_we       = 1'b1;
                  pv_waddr    = rd_next[IW-1:0];
                  pv_wdata    = LINK_NONE;
                end else begin
                  free_head_d = LINK_NONE;
                  free_tail_d = LINK_NONE;
                end
              end else begin
                ent_d  = bump_q;
                bump_d = bump_q + LW'(1);
              end
              if (used_tail_q < LINK_NONE) begin
                nx_we    = 1'b1;
                nx_waddr = used_tail_q[IW-1:0];
                nx_wdata = ent_d;
              end else begin
                used_head_d = ent_d;
              end
              used_tail_d = ent_d;
              aux_d       = used_tail_q;
              ok_d        = 1'b1;
              got_d       = ent_d;
            end
          end
          CMD_RELEASE: begin
            if (idx_ok) begin
              ent_d = idx_l;
              if (used_head_q == idx_l) used_head_d = rd_next;
              if (used_tail_q == idx_l) used_tail_d = rd_prev;
              if (rd_next < LINK_NONE) begin
                pv_we    = 1'b1;
                pv_waddr = rd_next[IW-1:0];
                pv_wdata = rd_prev;
              end
              if (rd_prev < LINK_NONE) begin
                nx_we    = 1'b1;
                nx_waddr = rd_prev[IW-1:0];
                nx_wdata = rd_next;
              end
              if (!(free_tail_q < LINK_NONE)) free_head_d = idx_l;
              free_tail_d = idx_l;
              aux_d       = free_tail_q;
            end
          end
          CMD_RELEASE_ALL: begin
            bump_d      = '0;
            free_head_d = LINK_NONE;
            free_tail_d = LINK_NONE;
            used_head_d = LINK_NONE;
            used_tail_d = LINK_NONE;
          end
          CMD_FIRST: begin
            if (used_head_q < LINK_NONE) begin
              ok_d  = 1'b1;
              got_d = used_head_q;
            end
          end
          CMD_NEXT: begin
            if (idx_ok && (rd_next < LINK_NONE)) begin
              ok_d  = 1'b1;
              got_d = rd_next;
            end
          end
          default: begin
            ok_d = 1'b0;
          end
        endcase
      end
      ST_WR2: begin
        if (req_q.cmd == CMD_RELEASE) begin
          if (aux_q < LINK_NONE) begin
            nx_we    = 1'b1;
            nx_waddr = aux_q[IW-1:0];
            nx_wdata = ent_q;
          end
        end else begin
          nx_we    = 1'b1;
          nx_waddr = ent_q[IW-1:0];
          nx_wdata = LINK_NONE;
        end
        pv_we    = 1'b1;
        pv_waddr = ent_q[IW-1:0];
        pv_wdata = (aux_q < LINK_NONE) ? aux_q : LINK_NONE;
      end
      ST_WR3: begin
        nx_we    = 1'b1;
        nx_waddr = ent_q[IW-1:0];
        nx_wdata = LINK_NONE;
      end
      ST_RESP: begin
        done_d    = 1'b1;
        rsp_d.ok  = ok_q;
        rsp_d.granted_index = ok_q ? IDX_W'(got_q) : '0;
        rsp_d.entry_address = ok_q ? (pool_base_q + 32'(got_q) * 32'(entry_stride_q)) : '0;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bump_q      <= '0;
      free_head_q <= LINK_NONE;
      free_tail_q <= LINK_NONE;
      used_head_q <= LINK_NONE;
      used_tail_q <= LINK_NONE;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      bump_q      <= bump_d;
      free_head_q <= free_head_d;
      free_tail_q <= free_tail_d;
      used_head_q <= used_head_d;
      used_tail_q <= used_tail_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_limit_q   <= POOL_LIMIT_RST;
      pool_base_q    <= POOL_BASE_RST;
      entry_stride_q <= ENTRY_STRIDE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_POOL_LIMIT:   pool_limit_q   <= cfg_data_i[LIMIT_W-1:0];
        REG_POOL_BASE:    pool_base_q    <= cfg_data_i[ADDR_W-1:0];
        REG_ENTRY_STRIDE: entry_stride_q <= cfg_data_i[STRIDE_W-1:0];
        default: begin
          pool_limit_q <= pool_limit_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    ent_q <= ent_d;
    aux_q <= aux_d;
    got_q <= got_d;
    ok_q  <= ok_d;
    rsp_q <= rsp_d;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pool_allocator_with_used_list_top: a directed table, then random
// phases across several register settings. Answers come from a behavioural model of the lists.
// Depends on pla_pkg and the RTL of the block; nothing else.
module testbench
  import pla_pkg::*;
();

  localparam logic [LIMIT_W-1:0] NO_ENTRY = LIMIT_W'(POOL_DEPTH_DEF);
  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam pla_rsp_t NO_ANSWER = '0;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic             typed;
    pla_rsp_t         ans;
  } opening_row_t;

  localparam opening_row_t OPENING_ROWS [24] = '{
    '{CMD_FIRST,       10'd0,    1'b1, NO_ANSWER},
    '{CMD_RELEASE_ALL, 10'd1023, 1'b1, NO_ANSWER},
    '{CMD_RSVD_5,      10'd1023, 1'b1, NO_ANSWER},
    '{CMD_RSVD_7,      10'd0,    1'b1, NO_ANSWER},
    '{CMD_ALLOC,       10'd1023, 1'b1, '{1'b1, 10'd0, 32'd0}},
    '{CMD_ALLOC,       10'd0,    1'b1, '{1'b1, 10'd1, 32'd64}},
    '{CMD_ALLOC,       10'd682,  1'b1, '{1'b1, 10'd2, 32'd128}},
    '{CMD_FIRST,       10'd0,    1'b1, '{1'b1, 10'd0, 32'd0}},
    '{CMD_NEXT,        10'd0,    1'b1, '{1'b1, 10'd1, 32'd64}},
    '{CMD_NEXT,        10'd2,    1'b1, NO_ANSWER},
    '{CMD_RELEASE,     10'd1,    1'b1, NO_ANSWER},
    '{CMD_NEXT,        10'd0,    1'b0, NO_ANSWER},
    '{CMD_RELEASE,     10'd0,    1'b1, NO_ANSWER},
    '{CMD_RELEASE,     10'd2,    1'b1, NO_ANSWER},
    '{CMD_FIRST,       10'd0,    1'b0, NO_ANSWER},
    '{CMD_NEXT,        10'd1,    1'b0, NO_ANSWER},
    '{CMD_ALLOC,       10'd0,    1'b0, NO_ANSWER},
    '{CMD_ALLOC,       10'd0,    1'b0, NO_ANSWER},
    '{CMD_RELEASE,     10'd1,    1'b0, NO_ANSWER},
    '{CMD_RELEASE,     10'd1,    1'b0, NO_ANSWER},
    '{CMD_RSVD_6,      10'd341,  1'b1, NO_ANSWER},
    '{CMD_RELEASE_ALL, 10'd0,    1'b1, NO_ANSWER},
    '{CMD_ALLOC,       10'd0,    1'b1, '{1'b1, 10'd0, 32'd0}},
    '{CMD_ALLOC,       10'd0,    1'b1, '{1'b1, 10'd1, 32'd64}}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  pla_req_t              req_i;
  logic                  done_o;
  pla_rsp_t              result_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [REG_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [LIMIT_W-1:0]  next_of [POOL_DEPTH_DEF];
  logic [LIMIT_W-1:0]  prev_of [POOL_DEPTH_DEF];
  logic [LIMIT_W-1:0]  bump_ptr;
  logic [LIMIT_W-1:0]  free_head;
  logic [LIMIT_W-1:0]  free_tail;
  logic [LIMIT_W-1:0]  used_head;
  logic [LIMIT_W-1:0]  used_tail;
  logic [LIMIT_W-1:0]  limit_reg;
  logic [ADDR_W-1:0]   base_reg;
  logic [STRIDE_W-1:0] stride_reg;

  pla_rsp_t         answers_due [$];
  logic [IDX_W-1:0] held_entries [$];
  logic [IDX_W-1:0] linked_entries [$];
  bit               ever_linked [POOL_DEPTH_DEF];
  int unsigned      mismatch_count = 0;
  bit               gaps_on;

  pool_allocator_with_used_list_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void link_at_tail(input bit onto_used, input logic [LIMIT_W-1:0] e);
    logic [LIMIT_W-1:0] tail;
    tail = onto_used ? used_tail : free_tail;
    if (tail < NO_ENTRY) begin
      next_of[tail[IDX_W-1:0]] = e;
      prev_of[e[IDX_W-1:0]] = tail;
    end else begin
      if (onto_used) used_head = e;
      else free_head = e;
      prev_of[e[IDX_W-1:0]] = NO_ENTRY;
    end
    next_of[e[IDX_W-1:0]] = NO_ENTRY;
    if (onto_used) used_tail = e;
    else free_tail = e;
  endfunction

  function automatic pla_rsp_t allocator_answer(input pla_req_t r);
    pla_rsp_t           ans;
    logic               found;
    logic [LIMIT_W-1:0] got;
    logic [LIMIT_W-1:0] nx;
    logic [LIMIT_W-1:0] pv;
    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W-1:0] e;
    logic [ADDR_W-1:0]  idx_w;
    logic [ADDR_W-1:0]  step_w;
    found = 1'b0;
    got = '0;
    e = {1'b0, r.entry_index};
    case (r.cmd)
      CMD_ALLOC: begin
        if (free_head < NO_ENTRY) begin
          got = free_head;
          nx = next_of[got[IDX_W-1:0]];
          if (nx < NO_ENTRY) begin
            free_head = nx;
            prev_of[nx[IDX_W-1:0]] = NO_ENTRY;
          end else begin
            free_head = NO_ENTRY;
            free_tail = NO_ENTRY;
          end
          found = 1'b1;
        end else begin
          lim = (limit_reg > NO_ENTRY) ? NO_ENTRY : limit_reg;
          if (bump_ptr < lim) begin
            got = bump_ptr;
            bump_ptr = bump_ptr + LIMIT_W'(1);
            found = 1'b1;
          end
        end
        if (found) link_at_tail(1'b1, got);
      end
      CMD_RELEASE: begin
        nx = next_of[r.entry_index];
        pv = prev_of[r.entry_index];
        if (used_head == e) used_head = nx;
        if (used_tail == e) used_tail = pv;
        if (nx < NO_ENTRY) prev_of[nx[IDX_W-1:0]] = pv;
        if (pv < NO_ENTRY) next_of[pv[IDX_W-1:0]] = nx;
        link_at_tail(1'b0, e);
      end
      CMD_RELEASE_ALL: begin
        bump_ptr = '0;
        free_head = NO_ENTRY;
        free_tail = NO_ENTRY;
        used_head = NO_ENTRY;
        used_tail = NO_ENTRY;
      end
      CMD_FIRST: begin
        if (used_head < NO_ENTRY) begin
          found = 1'b1;
          got = used_head;
        end
      end
      CMD_NEXT: begin
        nx = next_of[r.entry_index];
        if (nx < NO_ENTRY) begin
          found = 1'b1;
          got = nx;
        end
      end
      default: ;
    endcase
    ans = NO_ANSWER;
    if (found) begin
      idx_w = ADDR_W'(got);
      step_w = ADDR_W'(stride_reg);
      ans.ok = 1'b1;
      ans.granted_index = got[IDX_W-1:0];
      ans.entry_address = base_reg + idx_w * step_w;
    end
    return ans;
  endfunction

  task automatic issue(input pla_req_t r, input bit typed, input pla_rsp_t typed_ans);
    pla_rsp_t predicted;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = allocator_answer(r);
    answers_due.push_back(typed ? typed_ans : predicted);
    case (r.cmd)
      CMD_ALLOC: begin
        if (predicted.ok) begin
          held_entries.push_back(predicted.granted_index);
          if (!ever_linked[predicted.granted_index]) begin
            ever_linked[predicted.granted_index] = 1'b1;
            linked_entries.push_back(predicted.granted_index);
          end
        end
      end
      CMD_RELEASE: begin
        for (int i = held_entries.size() - 1; i >= 0; i--)
          if (held_entries[i] == r.entry_index) held_entries.delete(i);
      end
      CMD_RELEASE_ALL: held_entries.delete();
      default: ;
    endcase
  endtask

  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic random_gap();
    if (gaps_on && $urandom_range(99) < 12) pause_sender($urandom_range(1, 19));
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (answers_due.size() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_reg(input pla_reg_e r, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      REG_POOL_LIMIT:   limit_reg = d[LIMIT_W-1:0];
      REG_POOL_BASE:    base_reg = d;
      REG_ENTRY_STRIDE: stride_reg = d[STRIDE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input logic [ADDR_W-1:0] base,
                           input logic [STRIDE_W-1:0] stride, input int unsigned n,
                           input int unsigned alloc_pct, input bit wipe_ok, input bit fresh);
    pla_req_t    req;
    int unsigned roll;
    settle();
    write_reg(REG_POOL_LIMIT, lim);
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_ENTRY_STRIDE, stride);
    if (fresh) begin
      req.cmd = CMD_RELEASE_ALL;
      req.entry_index = IDX_W'($urandom_range(0, 1023));
      issue(req, 1'b0, NO_ANSWER);
    end
    for (int k = 0; k < n; k++) begin
      random_gap();
      if ($urandom_range(199) == 0) settle();
      req.entry_index = IDX_W'($urandom_range(0, 1023));
      if ($urandom_range(99) < alloc_pct) begin
        req.cmd = CMD_ALLOC;
      end else begin
        roll = $urandom_range(99);
        if (roll < 50) req.cmd = CMD_RELEASE;
        else if (roll < 62) req.cmd = CMD_FIRST;
        else if (roll < 88) req.cmd = CMD_NEXT;
        else if (roll < 93) req.cmd = wipe_ok ? CMD_RELEASE_ALL : CMD_FIRST;
        else req.cmd = CMD_RSVD_5 + 3'($urandom_range(0, 2));
      end
      if (req.cmd == CMD_RELEASE || req.cmd == CMD_NEXT) begin
        if (linked_entries.size() == 0)
          req.cmd = CMD_ALLOC;
        else if (held_entries.size() != 0 && $urandom_range(99) < 90)
          req.entry_index = held_entries[$urandom_range(0, held_entries.size() - 1)];
        else
          req.entry_index = linked_entries[$urandom_range(0, linked_entries.size() - 1)];
      end
      issue(req, 1'b0, NO_ANSWER);
    end
  endtask

  always @(posedge clk_i) begin
    pla_rsp_t want;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ok=%0b index=%0d address=%h",
                 $time, result_o.ok, result_o.granted_index, result_o.entry_address);
        mismatch_count++;
      end else begin
        want = answers_due.pop_front();
        if (result_o.ok !== want.ok) begin
          $display("%0t: ok mismatch, expected %0b actual %0b", $time, want.ok, result_o.ok);
          mismatch_count++;
        end
        if (result_o.granted_index !== want.granted_index) begin
          $display("%0t: granted_index mismatch, expected %0d actual %0d",
                   $time, want.granted_index, result_o.granted_index);
          mismatch_count++;
        end
        if (result_o.entry_address !== want.entry_address) begin
          $display("%0t: entry_address mismatch, expected %h actual %h",
                   $time, want.entry_address, result_o.entry_address);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    pla_req_t     req;
    opening_row_t row;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_POOL_LIMIT;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    gaps_on = 1'b1;
    limit_reg = POOL_LIMIT_RST;
    base_reg = POOL_BASE_RST;
    stride_reg = ENTRY_STRIDE_RST;
    bump_ptr = '0;
    free_head = NO_ENTRY;
    free_tail = NO_ENTRY;
    used_head = NO_ENTRY;
    used_tail = NO_ENTRY;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < $size(OPENING_ROWS); i++) begin
      random_gap();
      row = OPENING_ROWS[i];
      req.cmd = row.cmd;
      req.entry_index = row.idx;
      issue(req, row.typed, row.ans);
    end

    run_phase(11'd0, 32'hFFFF_FFFF, 16'hFFFF, 40, 40, 1'b1, 1'b1);
    run_phase(11'd1, 32'd0, 16'd1, 40, 50, 1'b1, 1'b1);
    run_phase(11'd12, $urandom, STRIDE_W'($urandom_range(1, 65535)), 80, 55, 1'b1, 1'b1);
    run_phase(11'd1024, 32'hFFFF_F000, 16'hFFFF, 280, 97, 1'b0, 1'b1);
    run_phase(11'd1024, $urandom, STRIDE_W'($urandom_range(1, 65535)), 50, 50, 1'b1, 1'b0);
    run_phase(LIMIT_W'($urandom_range(2, 300)), $urandom, STRIDE_W'($urandom_range(1, 65535)),
              80, 55, 1'b1, 1'b1);
    gaps_on = 1'b0;
    run_phase(LIMIT_W'($urandom_range(1, 1024)), $urandom, STRIDE_W'($urandom_range(1, 65535)),
              60, 55, 1'b1, 1'b1);

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
